[sv/clnib_pkg.sv]
package clnib_pkg;

	// Request codes carried on the input tuser
	typedef enum logic [3:0] {
		FN_INIT      = 4'd0,
		FN_COMMAND   = 4'd1,
		FN_DATA      = 4'd2,
		FN_CURSOR    = 4'd3,
		FN_DISPLAY   = 4'd4,
		FN_SHOW_CUR  = 4'd5,
		FN_BLINK     = 4'd6,
		FN_DIRECTION = 4'd7,
		FN_AUTOSCRL  = 4'd8,
		FN_SCROLL    = 4'd9,
		FN_CLEAR     = 4'd10,
		FN_HOME      = 4'd11,
		FN_CGRAM     = 4'd12
	} func_t;

	localparam int unsigned NIB_W     = 4;
	localparam int unsigned MAX_PULSE = 12;
	localparam int unsigned SEQ_W     = NIB_W * MAX_PULSE;
	localparam int unsigned CNT_W     = 4;

	// Init run, first nibble in the lowest bits: 3,3,3,2, 0x28, 0x0C, 0x01, 0x06
	localparam logic [SEQ_W-1:0] INIT_SEQ   = 48'h6010C0822333;
	localparam logic [CNT_W-1:0] INIT_COUNT = 4'd12;
	localparam logic [CNT_W-1:0] BYTE_COUNT = 4'd2;

	// Pulse index within init that carries the low nibble of the clear
	localparam logic [CNT_W-1:0] INIT_CLEAR_LO = 4'd9;
	localparam logic [CNT_W-1:0] INIT_WAKE_3   = 4'd2;

	// Command bytes and bit fields
	localparam logic [7:0] CMD_CLEAR   = 8'h01;
	localparam logic [7:0] CMD_HOME    = 8'h02;
	localparam logic [7:0] CMD_ENTRY   = 8'h04;
	localparam logic [7:0] CMD_CONTROL = 8'h08;
	localparam logic [7:0] CMD_SHIFT   = 8'h18;
	localparam logic [7:0] CMD_DDRAM   = 8'h80;

	localparam logic [2:0] DC_DISPLAY = 3'b100;
	localparam logic [2:0] DC_CURSOR  = 3'b010;
	localparam logic [2:0] DC_BLINK   = 3'b001;
	localparam logic [1:0] EM_LTR     = 2'b10;
	localparam logic [1:0] EM_SHIFT   = 2'b01;

	// Waits in microseconds
	localparam logic [12:0] SETTLE_BASE = 13'd100;
	localparam logic [12:0] SETTLE_WAKE = 13'd4600;
	localparam logic [12:0] SETTLE_W3   = 13'd250;
	localparam logic [12:0] SETTLE_SLOW = 13'd2100;
	localparam logic [15:0] POWER_WAIT  = 16'd50000;

	// Loaded run for the serialiser
	typedef struct packed {
		logic [SEQ_W-1:0] nibs;
		logic [CNT_W-1:0] count;
		logic             rs;
		logic             init;
		logic             slow;
	} run_t;

endpackage

[sv/clnib_decode.sv]
module clnib_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [3:0]           func,
	input  logic [7:0]           data_byte,
	input  logic [5:0]           column,
	input  logic [1:0]           line,
	input  logic                 flag_on,
	input  logic [2:0]           cgram_slot,
	output clnib_pkg::run_t      run
);

	logic [2:0] disp_q;
	logic [1:0] entry_q;
	logic [2:0] disp_nx;
	logic [1:0] entry_nx;
	logic [7:0] byte_v;
	logic       row_v;
	logic [6:0] addr_v;

	// Cursor address, row clamped to one
	assign row_v  = line[1] | line[0];
	assign addr_v = {1'b0, column} + {row_v, 6'b0};

	// Request to byte, flag updates
	always_comb begin
		disp_nx   = disp_q;
		entry_nx  = entry_q;
		byte_v    = 8'h00;
		run       = '0;
		run.count = clnib_pkg::BYTE_COUNT;
		case (clnib_pkg::func_t'(func))
			clnib_pkg::FN_INIT: begin
				disp_nx   = clnib_pkg::DC_DISPLAY;
				entry_nx  = clnib_pkg::EM_LTR;
				run.init  = 1'b1;
				run.slow  = 1'b1;
				run.count = clnib_pkg::INIT_COUNT;
			end
			clnib_pkg::FN_COMMAND: byte_v = data_byte;
			clnib_pkg::FN_DATA: begin
				byte_v = data_byte;
				run.rs = 1'b1;
			end
			clnib_pkg::FN_CURSOR: byte_v = clnib_pkg::CMD_DDRAM | {1'b0, addr_v};
			clnib_pkg::FN_DISPLAY, clnib_pkg::FN_SHOW_CUR, clnib_pkg::FN_BLINK: begin
				if (clnib_pkg::func_t'(func) == clnib_pkg::FN_DISPLAY) begin
					disp_nx = flag_on ? (disp_q | clnib_pkg::DC_DISPLAY)
						: (disp_q & ~clnib_pkg::DC_DISPLAY);
				end else if (clnib_pkg::func_t'(func) == clnib_pkg::FN_SHOW_CUR) begin
					disp_nx = flag_on ? (disp_q | clnib_pkg::DC_CURSOR)
						: (disp_q & ~clnib_pkg::DC_CURSOR);
				end else begin
					disp_nx = flag_on ? (disp_q | clnib_pkg::DC_BLINK)
						: (disp_q & ~clnib_pkg::DC_BLINK);
				end
				byte_v = clnib_pkg::CMD_CONTROL | {5'b0, disp_nx};
			end
			clnib_pkg::FN_DIRECTION, clnib_pkg::FN_AUTOSCRL: begin
				if (clnib_pkg::func_t'(func) == clnib_pkg::FN_DIRECTION) begin
					entry_nx = flag_on ? (entry_q | clnib_pkg::EM_LTR)
						: (entry_q & ~clnib_pkg::EM_LTR);
				end else begin
					entry_nx = flag_on ? (entry_q | clnib_pkg::EM_SHIFT)
						: (entry_q & ~clnib_pkg::EM_SHIFT);
				end
				byte_v = clnib_pkg::CMD_ENTRY | {6'b0, entry_nx};
			end
			clnib_pkg::FN_SCROLL: byte_v = clnib_pkg::CMD_SHIFT | {5'b0, flag_on, 2'b0};
			clnib_pkg::FN_CLEAR: begin
				byte_v   = clnib_pkg::CMD_CLEAR;
				run.slow = 1'b1;
			end
			clnib_pkg::FN_HOME: begin
				byte_v   = clnib_pkg::CMD_HOME;
				run.slow = 1'b1;
			end
			clnib_pkg::FN_CGRAM: byte_v = {2'b01, cgram_slot, 3'b000};
			default: run.count = '0;
		endcase
		// High nibble goes out first
		if (run.init) begin
			run.nibs = clnib_pkg::INIT_SEQ;
		end else begin
			run.nibs = {{(clnib_pkg::SEQ_W - 8){1'b0}}, byte_v[3:0], byte_v[7:4]};
		end
	end

	// Flag state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_q  <= '0;
			entry_q <= '0;
		end else if (take) begin
			disp_q  <= disp_nx;
			entry_q <= entry_nx;
		end
	end

endmodule

[sv/clnib_shift.sv]
module clnib_shift (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  clnib_pkg::run_t      run,
	output logic                 idle,
	output logic                 pulse_valid,
	input  logic                 pulse_ready,
	output logic                 pulse_rs,
	output logic [3:0]           pulse_nibble,
	output logic [15:0]          pulse_pre,
	output logic [12:0]          pulse_settle,
	output logic                 pulse_last
);

	logic [clnib_pkg::SEQ_W-1:0] seq_q;
	logic [clnib_pkg::CNT_W-1:0] rem_q;
	logic [clnib_pkg::CNT_W-1:0] idx_q;
	logic                        rs_q;
	logic                        init_q;
	logic                        slow_q;
	logic                        valid_q;
	logic                        rs_o_q;
	logic [3:0]                  nib_o_q;
	logic [15:0]                 pre_o_q;
	logic [12:0]                 settle_o_q;
	logic                        last_o_q;
	logic                        step;
	logic [15:0]                 pre_v;
	logic [12:0]                 settle_v;

	assign idle = (rem_q == '0);
	assign step = !idle && (!valid_q || pulse_ready);

	// Waits for the pulse about to leave
	always_comb begin
		pre_v    = '0;
		settle_v = clnib_pkg::SETTLE_BASE;
		if (init_q) begin
			if (idx_q == '0) begin
				pre_v    = clnib_pkg::POWER_WAIT;
				settle_v = clnib_pkg::SETTLE_WAKE;
			end else if (idx_q == 4'd1) begin
				settle_v = clnib_pkg::SETTLE_WAKE;
			end else if (idx_q == clnib_pkg::INIT_WAKE_3) begin
				settle_v = clnib_pkg::SETTLE_W3;
			end else if (idx_q == clnib_pkg::INIT_CLEAR_LO) begin
				settle_v = clnib_pkg::SETTLE_SLOW;
			end
		end else if (slow_q && rem_q == 4'd1) begin
			settle_v = clnib_pkg::SETTLE_SLOW;
		end
	end

	// Nibble shift register and run control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			rem_q <= run.count;
			idx_q <= '0;
		end else if (step) begin
			rem_q <= rem_q - 1'b1;
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			seq_q  <= run.nibs;
			rs_q   <= run.rs;
			init_q <= run.init;
			slow_q <= run.slow;
		end else if (step) begin
			seq_q <= {{clnib_pkg::NIB_W{1'b0}}, seq_q[clnib_pkg::SEQ_W-1:clnib_pkg::NIB_W]};
		end
	end

	// Output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= 1'b1;
		end else if (pulse_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rs_o_q     <= rs_q;
			nib_o_q    <= seq_q[clnib_pkg::NIB_W-1:0];
			pre_o_q    <= pre_v;
			settle_o_q <= settle_v;
			last_o_q   <= (rem_q == 4'd1);
		end
	end

	assign pulse_valid  = valid_q;
	assign pulse_rs     = rs_o_q;
	assign pulse_nibble = nib_o_q;
	assign pulse_pre    = pre_o_q;
	assign pulse_settle = settle_o_q;
	assign pulse_last   = last_o_q;

endmodule

[sv/char_lcd_nibble_interface_top.sv]
// Order: an accepted request is loaded into the nibble shift register; each pulse beat
//   is then registered in the output beat register. Throughput: one pulse beat per cycle
//   unless m_tready stalls; a request of n pulses (12 for init, 2 otherwise) keeps
//   s_tready low until its last pulse is registered; an unused code gives no pulses.
// Reset: arst_n clears the run counter, the output valid and the display and
//   entry flags at once; the block is ready once reset is released.
module char_lcd_nibble_interface_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // data_byte, column, line, flag_on, cgram_slot, zero pad
	input  logic [3:0]  s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // reg_select, nibble, pre_wait_us, settle_us, zero pad
	output logic        m_tlast
);

	clnib_pkg::run_t run;
	logic            idle;
	logic            take;
	logic            o_rs;
	logic [3:0]      o_nib;
	logic [15:0]     o_pre;
	logic [12:0]     o_settle;

	assign s_tready = idle;
	assign take     = s_tvalid && idle;

	clnib_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.func       (s_tuser),
		.data_byte  (s_tdata[7:0]),
		.column     (s_tdata[13:8]),
		.line       (s_tdata[15:14]),
		.flag_on    (s_tdata[16]),
		.cgram_slot (s_tdata[19:17]),
		.run        (run)
	);

	clnib_shift u_shift (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (take),
		.run          (run),
		.idle         (idle),
		.pulse_valid  (m_tvalid),
		.pulse_ready  (m_tready),
		.pulse_rs     (o_rs),
		.pulse_nibble (o_nib),
		.pulse_pre    (o_pre),
		.pulse_settle (o_settle),
		.pulse_last   (m_tlast)
	);

	// Pack the result beat
	assign m_tdata = {6'b0, o_settle, o_pre, o_nib, o_rs};

endmodule
